FILE: sv/hsv_pkg.sv
package hsv_pkg;

  localparam int FRACTION_BITS_DEF = 12;
  localparam int STAGES = 5;

  localparam int HUE_FULL = 5760;
  localparam int HUE_SECTOR = 960;
  localparam int HUE_OFFSET = 6 * HUE_FULL;
  localparam int HUE_LOW_BITS = 7;
  localparam int HUE_ODD = HUE_FULL >> HUE_LOW_BITS;
  // floor(n / 45) = (n * 1457) >> 16 for n < 2259
  localparam int HUE_RECIP = 1457;
  localparam int HUE_RECIP_SHIFT = 16;
  // floor(n / 15) = (n * 34953) >> 19 for n < 74898
  localparam int LEVEL_RECIP = 34953;
  localparam int LEVEL_RECIP_SHIFT = 19;

  localparam logic [7:0] ALPHA_VALUE = 8'hFF;

  localparam logic [2:0] SECTOR_RED_YEL = 3'd0;
  localparam logic [2:0] SECTOR_YEL_GRN = 3'd1;
  localparam logic [2:0] SECTOR_GRN_CYN = 3'd2;
  localparam logic [2:0] SECTOR_CYN_BLU = 3'd3;
  localparam logic [2:0] SECTOR_BLU_MAG = 3'd4;
  localparam logic [2:0] SECTOR_MAG_RED = 3'd5;

  typedef struct packed {
    logic [2:0] sector;
    logic [9:0] ramp;
  } hsv_hue_t;

endpackage

FILE: sv/hsv_to_rgb_converter.sv
// HSV to RGB converter, five-stage pipeline: one pixel per clock while pixel_stall is low.
// Hue is signed 1/16 degree and wraps modulo 360 degrees; saturation and brightness are
// signed Q4.FRACTION_BITS clamped to 0..1. Each channel is the exact truncation of
// (channel' + m) * 255, and packed_color carries RGBA with alpha fixed at 255. Every stage
// holds only while the stage after it is full and stalled, so empty slots close up under a
// stalled output and pixel_stall is low whenever the output register is empty.
module hsv_to_rgb_converter #(
  parameter int FRACTION_BITS = hsv_pkg::FRACTION_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               pixel_valid,
  output logic               pixel_stall,
  input  logic signed [15:0] hue,
  input  logic signed [15:0] saturation,
  input  logic signed [15:0] brightness,
  output logic               color_valid,
  input  logic               color_stall,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [31:0]        packed_color
);
  import hsv_pkg::*;

  logic [STAGES-1:0] valid_q;
  logic [STAGES-1:0] valid_next;
  logic [STAGES-1:0] en;

  always_comb begin
    en[STAGES-1] = !valid_q[STAGES-1] || !color_stall;
    for (int i = STAGES - 2; i >= 0; i--) begin
      en[i] = !valid_q[i] || en[i+1];
    end
  end

  assign valid_next = {valid_q[STAGES-2:0], pixel_valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      for (int i = 0; i < STAGES; i++) begin
        if (en[i]) begin
          valid_q[i] <= valid_next[i];
        end
      end
    end
  end

  assign pixel_stall = !en[0];
  assign color_valid = valid_q[STAGES-1];

  hsv_hue_t                 hue_info;
  logic [FRACTION_BITS:0]   level;
  logic [2*FRACTION_BITS:0] chroma;
  logic [2*FRACTION_BITS:0] floor_term;

  hsv_sector #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_sector (
    .clk        (clk),
    .en         (en[1:0]),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .hue_info   (hue_info),
    .level      (level),
    .chroma     (chroma),
    .floor_term (floor_term)
  );

  hsv_level #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_level (
    .clk        (clk),
    .en         (en[4:2]),
    .hue_info   (hue_info),
    .level      (level),
    .chroma     (chroma),
    .floor_term (floor_term),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  assign packed_color = {red, green, blue, ALPHA_VALUE};

endmodule

FILE: sv/hsv_sector.sv
module hsv_sector #(
  parameter int FRACTION_BITS = hsv_pkg::FRACTION_BITS_DEF
) (
  input  logic                           clk,
  input  logic [1:0]                     en,
  input  logic signed [15:0]             hue,
  input  logic signed [15:0]             saturation,
  input  logic signed [15:0]             brightness,
  output hsv_pkg::hsv_hue_t              hue_info,
  output logic [FRACTION_BITS:0]         level,
  output logic [2*FRACTION_BITS:0]       chroma,
  output logic [2*FRACTION_BITS:0]       floor_term
);
  import hsv_pkg::*;

  localparam int F = FRACTION_BITS;
  localparam logic signed [15:0] ONE_Q = 16'(1 << F);

  function automatic logic [F:0] clamp_unit(input logic signed [15:0] q);
    logic [F:0] r;
    if (q < 16'sd0) begin
      r = '0;
    end else if (q > ONE_Q) begin
      r = ONE_Q[F:0];
    end else begin
      r = q[F:0];
    end
    return r;
  endfunction

  // stage 1: hue offset into positive range, coarse quotient by 45; chroma product
  logic [16:0]    hue_ofs;
  logic [20:0]    quot_prod;
  logic [F:0]     sat_c;
  logic [F:0]     val_c;
  logic [2*F+1:0] prod_full;

  assign hue_ofs   = {hue[15], hue} + 17'(HUE_OFFSET);
  assign quot_prod = 21'(hue_ofs[16:HUE_LOW_BITS]) * 21'(HUE_RECIP);
  assign sat_c     = clamp_unit(saturation);
  assign val_c     = clamp_unit(brightness);
  assign prod_full = {{(F+1){1'b0}}, val_c} * {{(F+1){1'b0}}, sat_c};

  logic [9:0]  hue_hi;
  logic [6:0]  hue_lo;
  logic [4:0]  hue_quot;
  logic [F:0]  level1;
  logic [2*F:0] chroma1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hue_hi   <= hue_ofs[16:HUE_LOW_BITS];
      hue_lo   <= hue_ofs[HUE_LOW_BITS-1:0];
      hue_quot <= quot_prod[20:HUE_RECIP_SHIFT];
      level1   <= val_c;
      chroma1  <= prod_full[2*F:0];
    end
  end

  // stage 2: wrapped hue, sector, ramp within sector
  logic [9:0]  hue_rem;
  logic [12:0] hue_wrap;
  logic [2:0]  sector;
  logic [12:0] frac_full;
  logic [9:0]  frac;
  logic [9:0]  ramp;

  assign hue_rem  = hue_hi - 10'(hue_quot) * 10'(HUE_ODD);
  assign hue_wrap = {hue_rem[5:0], hue_lo};

  always_comb begin
    if (hue_wrap >= 13'(5 * HUE_SECTOR)) begin
      sector = SECTOR_MAG_RED;
    end else if (hue_wrap >= 13'(4 * HUE_SECTOR)) begin
      sector = SECTOR_BLU_MAG;
    end else if (hue_wrap >= 13'(3 * HUE_SECTOR)) begin
      sector = SECTOR_CYN_BLU;
    end else if (hue_wrap >= 13'(2 * HUE_SECTOR)) begin
      sector = SECTOR_GRN_CYN;
    end else if (hue_wrap >= 13'(HUE_SECTOR)) begin
      sector = SECTOR_YEL_GRN;
    end else begin
      sector = SECTOR_RED_YEL;
    end
  end

  assign frac_full = hue_wrap - 13'(sector) * 13'(HUE_SECTOR);
  assign frac      = frac_full[9:0];
  assign ramp      = sector[0] ? (10'(HUE_SECTOR) - frac) : frac;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      hue_info.sector <= sector;
      hue_info.ramp   <= ramp;
      level           <= level1;
      chroma          <= chroma1;
      floor_term      <= {level1, {F{1'b0}}} - chroma1;
    end
  end

endmodule

FILE: sv/hsv_level.sv
module hsv_level #(
  parameter int FRACTION_BITS = hsv_pkg::FRACTION_BITS_DEF
) (
  input  logic                     clk,
  input  logic [2:0]               en,
  input  hsv_pkg::hsv_hue_t        hue_info,
  input  logic [FRACTION_BITS:0]   level,
  input  logic [2*FRACTION_BITS:0] chroma,
  input  logic [2*FRACTION_BITS:0] floor_term,
  output logic [7:0]               red,
  output logic [7:0]               green,
  output logic [7:0]               blue
);
  import hsv_pkg::*;

  localparam int F = FRACTION_BITS;

  // stage 3: ramp term in units of 1/(one*one*960); full and base bytes
  logic [2*F+10:0] ramp_prod;
  logic [2*F+10:0] base_960;
  logic [2*F+10:0] ramp_sum;
  logic [F+8:0]    full_255;
  logic [2*F+8:0]  base_255;

  assign ramp_prod = (2*F+11)'(chroma) * (2*F+11)'(hue_info.ramp);
  assign base_960  = ((2*F+11)'(floor_term) << 10) - ((2*F+11)'(floor_term) << 6);
  assign ramp_sum  = ramp_prod + base_960;
  assign full_255  = {level, 8'b0} - (F+9)'(level);
  assign base_255  = {floor_term, 8'b0} - (2*F+9)'(floor_term);

  logic [2*F+9:0] ramp3;
  logic [2:0]     sector3;
  logic [7:0]     full3;
  logic [7:0]     base3;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ramp3   <= ramp_sum[2*F+9:0];
      sector3 <= hue_info.sector;
      full3   <= full_255[F+7:F];
      base3   <= base_255[2*F+7:2*F];
    end
  end

  // stage 4: scale by 255, drop the power-of-two part of the divisor
  logic [2*F+17:0] ramp_255;

  assign ramp_255 = {ramp3, 8'b0} - (2*F+18)'(ramp3);

  logic [11:0] ramp4;
  logic [2:0]  sector4;
  logic [7:0]  full4;
  logic [7:0]  base4;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ramp4   <= ramp_255[2*F+17:2*F+6];
      sector4 <= sector3;
      full4   <= full3;
      base4   <= base3;
    end
  end

  // stage 5: divide by 15, route bytes to channels
  logic [27:0] div_prod;
  logic [7:0]  ramp_byte;

  assign div_prod  = 28'(ramp4) * 28'(LEVEL_RECIP);
  assign ramp_byte = div_prod[LEVEL_RECIP_SHIFT+7:LEVEL_RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (en[2]) begin
      case (sector4)
        SECTOR_RED_YEL: begin
          red <= full4;     green <= ramp_byte; blue <= base4;
        end
        SECTOR_YEL_GRN: begin
          red <= ramp_byte; green <= full4;     blue <= base4;
        end
        SECTOR_GRN_CYN: begin
          red <= base4;     green <= full4;     blue <= ramp_byte;
        end
        SECTOR_CYN_BLU: begin
          red <= base4;     green <= ramp_byte; blue <= full4;
        end
        SECTOR_BLU_MAG: begin
          red <= ramp_byte; green <= base4;     blue <= full4;
        end
        default: begin
          red <= full4;     green <= base4;     blue <= ramp_byte;
        end
      endcase
    end
  end

endmodule

FILE: sv/hsv_checker.sv
module hsv_checker (
  input logic        clk,
  input logic        rst,
  input logic        pixel_valid,
  input logic        pixel_stall,
  input logic        color_valid,
  input logic        color_stall,
  input logic [7:0]  red,
  input logic [7:0]  green,
  input logic [7:0]  blue,
  input logic [31:0] packed_color
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !color_valid)
    else $error("color beat right after reset");

  a_empty_no_stall: assert property (@(posedge clk) disable iff (rst)
    !color_valid |-> !pixel_stall)
    else $error("pixel stalled with empty output");

  a_packed_match: assert property (@(posedge clk) disable iff (rst)
    color_valid |-> (packed_color[31:8] == {red, green, blue}) && (packed_color[7:0] == 8'hFF))
    else $error("packed color disagrees with channels");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && color_stall |=> color_valid && $stable(red) && $stable(green)
      && $stable(blue))
    else $error("stalled color beat changed");

endmodule

bind hsv_to_rgb_converter hsv_checker u_hsv_checker (.*);
